// ===== hw/rtl/text_console_writer_assert.svh =====
// ----------------------------------------------------------------------------
// text console writer assertion macros
// concurrent checks clocked on clock and held off during reset
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`ifndef SYNTH
`define TCW_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define TCW_ASSERT_NEVER(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define TCW_ASSERT(name, prop, msg)
`define TCW_ASSERT_NEVER(name, cond, msg)
`endif

`endif

// ===== hw/rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// text console writer package
// screen geometry, field widths, character codes and cell helper
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int DEPTH   = ROWS * COLUMNS;

   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ADDR_W = $clog2(DEPTH);

   localparam int CHAR_W = 8;
   localparam int CELL_W = 16;
   localparam int RROW_W = 5;
   localparam int RCOL_W = 7;
   localparam int POS_W  = 11;

   localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'h07;

   typedef enum logic {
      CMD_PUT  = 1'b0,
      CMD_READ = 1'b1
   } command_type;

   function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                   input logic [CHAR_W-1:0] color);
      return {color, ch};
   endfunction

endpackage

// ===== hw/rtl/tcw_if.sv =====
// ----------------------------------------------------------------------------
// text console writer channels
// request, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface tcw_req_if;
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic [tcw_pkg::CHAR_W-1:0]  char_code;
   logic [tcw_pkg::RROW_W-1:0]  read_row;
   logic [tcw_pkg::RCOL_W-1:0]  read_col;

   modport source (output valid, command, char_code, read_row, read_col, input ready);
   modport sink   (input valid, command, char_code, read_row, read_col, output ready);
endinterface

interface tcw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tcw_pkg::CELL_W-1:0]  cell_value;
   logic [tcw_pkg::RROW_W-1:0]  cursor_row;
   logic [tcw_pkg::RCOL_W-1:0]  cursor_col;
   logic [tcw_pkg::POS_W-1:0]   cursor_position;
   logic                        scrolled;

   modport source (output valid, cell_value, cursor_row, cursor_col, cursor_position,
                   scrolled, input ready);
   modport sink   (input valid, cell_value, cursor_row, cursor_col, cursor_position,
                   scrolled, output ready);
endinterface

interface tcw_csr_if;
   logic                        valid;
   logic                        ready;
   logic [tcw_pkg::CHAR_W-1:0]  text_color;

   modport source (output valid, text_color, input ready);
   modport sink   (input valid, text_color, output ready);
endinterface

// ===== hw/rtl/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text console writer
// Text screen of COLUMNS x ROWS cells (character low byte, colour high byte)
// held in one synchronous memory, with a cursor. Rows are kept as a ring:
// a scroll moves the top-row pointer and blanks the freed row in the current
// colour, one cell a cycle. After reset the whole memory is blanked in light
// grey before the first request transfer; register writes are taken at any
// time. A put or newline goes through the execute and access states before
// the next request is taken; a read adds a wait for the registered memory
// read, and a put or newline that scrolls adds the row blanking pass. The
// response register lets the next request in while a result still waits to
// be taken.
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module text_console_writer (
   input  logic      clock,
   input  logic      reset,
   tcw_req_if.sink   req,
   tcw_rsp_if.source rsp,
   tcw_csr_if.sink   csr
);

   typedef enum logic [5:0] {
      S_INIT   = 6'b000001,
      S_IDLE   = 6'b000010,
      S_EXEC   = 6'b000100,
      S_ACCESS = 6'b001000,
      S_RDWAIT = 6'b010000,
      S_CLEAR  = 6'b100000
   } state_type;

   state_type                      state_ff, state_in;
   logic                           done_ff, done_in;
   logic [tcw_pkg::ROW_W-1:0]      cur_row_ff, cur_row_in;
   logic [tcw_pkg::COL_W-1:0]      cur_col_ff, cur_col_in;
   logic [tcw_pkg::ROW_W-1:0]      top_ff, top_in;
   logic [tcw_pkg::CHAR_W-1:0]     color_ff, color_in;
   logic [tcw_pkg::ADDR_W-1:0]     init_addr_ff, init_addr_in;

   logic                           item_cmd_ff;
   logic [tcw_pkg::CHAR_W-1:0]     item_char_ff;
   logic [tcw_pkg::RROW_W-1:0]     item_rrow_ff;
   logic [tcw_pkg::RCOL_W-1:0]     item_rcol_ff;

   logic [tcw_pkg::ROW_W-1:0]      acc_row_ff, acc_row_in;
   logic [tcw_pkg::COL_W-1:0]      acc_col_ff, acc_col_in;
   logic                           acc_we_ff, acc_we_in;
   logic                           in_range_ff, in_range_in;
   logic                           scroll_ff, scroll_in;
   logic [tcw_pkg::CELL_W-1:0]     res_cell_ff, res_cell_in;
   logic [tcw_pkg::ADDR_W-1:0]     clr_addr_ff, clr_addr_in;
   logic [tcw_pkg::COL_W-1:0]      clr_cnt_ff, clr_cnt_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::CELL_W-1:0]     rsp_cell_ff, rsp_cell_in;
   logic [tcw_pkg::RROW_W-1:0]     rsp_row_ff, rsp_row_in;
   logic [tcw_pkg::RCOL_W-1:0]     rsp_col_ff, rsp_col_in;
   logic [tcw_pkg::POS_W-1:0]      rsp_pos_ff, rsp_pos_in;
   logic                           rsp_scroll_ff, rsp_scroll_in;

   logic [tcw_pkg::CELL_W-1:0]     screen_ff [tcw_pkg::DEPTH];
   logic [tcw_pkg::CELL_W-1:0]     rd_data_ff;

   logic                           req_xfer;
   logic                           rsp_free;
   logic [tcw_pkg::ROW_W:0]        phys_sum;
   logic [tcw_pkg::ROW_W-1:0]      phys_row;
   logic [tcw_pkg::ADDR_W-1:0]     acc_addr;
   logic [tcw_pkg::ADDR_W-1:0]     clr_base;
   logic                           mem_we;
   logic [tcw_pkg::ADDR_W-1:0]     mem_waddr;
   logic [tcw_pkg::CELL_W-1:0]     mem_wdata;
   logic [tcw_pkg::CELL_W-1:0]     blank_cell;

   assign req.ready      = (state_ff == S_IDLE) && !done_ff;
   assign csr.ready      = 1'b1;
   assign req_xfer       = req.valid && req.ready;
   assign rsp_free       = !rsp_valid_ff || rsp.ready;

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.cell_value      = rsp_cell_ff;
   assign rsp.cursor_row      = rsp_row_ff;
   assign rsp.cursor_col      = rsp_col_ff;
   assign rsp.cursor_position = rsp_pos_ff;
   assign rsp.scrolled        = rsp_scroll_ff;

   assign blank_cell = tcw_pkg::make_cell(tcw_pkg::CH_SPACE, color_ff);

   // logical row to ring row, then cell address
   assign phys_sum = {1'b0, acc_row_ff} + {1'b0, top_ff};
   assign phys_row = (phys_sum >= (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS))
                   ? tcw_pkg::ROW_W'(phys_sum - (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS))
                   : tcw_pkg::ROW_W'(phys_sum);
   assign acc_addr = tcw_pkg::ADDR_W'(int'(phys_row) * tcw_pkg::COLUMNS + int'(acc_col_ff));
   assign clr_base = tcw_pkg::ADDR_W'(int'(top_ff) * tcw_pkg::COLUMNS);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = acc_addr;
      mem_wdata = res_cell_ff;
      case (state_ff)
         S_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = init_addr_ff;
            mem_wdata = tcw_pkg::make_cell(tcw_pkg::CH_SPACE, tcw_pkg::RESET_COLOR);
         end
         S_ACCESS: begin
            mem_we    = acc_we_ff;
            mem_waddr = acc_addr;
            mem_wdata = res_cell_ff;
         end
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = blank_cell;
         end
         default: begin
            mem_we    = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= screen_ff[acc_addr];
   end

   always_comb begin
      state_in      = state_ff;
      done_in       = done_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      top_in        = top_ff;
      color_in      = color_ff;
      init_addr_in  = init_addr_ff;
      acc_row_in    = acc_row_ff;
      acc_col_in    = acc_col_ff;
      acc_we_in     = acc_we_ff;
      in_range_in   = in_range_ff;
      scroll_in     = scroll_ff;
      res_cell_in   = res_cell_ff;
      clr_addr_in   = clr_addr_ff;
      clr_cnt_in    = clr_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_cell_in   = rsp_cell_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_scroll_in = rsp_scroll_ff;

      if (csr.valid && csr.ready) begin
         color_in = csr.text_color;
      end

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      // finished result waits here until the response register is free
      if (done_ff && rsp_free) begin
         done_in       = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_cell_in   = res_cell_ff;
         rsp_row_in    = tcw_pkg::RROW_W'(cur_row_ff);
         rsp_col_in    = tcw_pkg::RCOL_W'(cur_col_ff);
         rsp_pos_in    = tcw_pkg::POS_W'(int'(cur_row_ff) * tcw_pkg::COLUMNS
                                         + int'(cur_col_ff));
         rsp_scroll_in = scroll_ff;
      end

      case (state_ff)
         S_INIT: begin
            init_addr_in = init_addr_ff + 1'b1;
            if (init_addr_ff == tcw_pkg::ADDR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in    = S_ACCESS;
            acc_we_in   = 1'b0;
            scroll_in   = 1'b0;
            in_range_in = 1'b0;
            res_cell_in = '0;
            acc_row_in  = cur_row_ff;
            acc_col_in  = cur_col_ff;
            if (item_cmd_ff == tcw_pkg::CMD_READ) begin
               in_range_in = (int'(item_rrow_ff) < tcw_pkg::ROWS)
                          && (int'(item_rcol_ff) < tcw_pkg::COLUMNS);
               if (in_range_in) begin
                  acc_row_in = tcw_pkg::ROW_W'(item_rrow_ff);
                  acc_col_in = tcw_pkg::COL_W'(item_rcol_ff);
               end else begin
                  acc_row_in = '0;
                  acc_col_in = '0;
               end
            end else if (item_char_ff == tcw_pkg::CH_BACKSPACE) begin
               if (cur_col_ff != '0) begin
                  cur_col_in = cur_col_ff - 1'b1;
               end else if (cur_row_ff != '0) begin
                  cur_row_in = cur_row_ff - 1'b1;
                  cur_col_in = tcw_pkg::COL_LAST;
               end
               acc_row_in  = cur_row_in;
               acc_col_in  = cur_col_in;
               acc_we_in   = 1'b1;
               res_cell_in = blank_cell;
            end else if (item_char_ff == tcw_pkg::CH_NEWLINE) begin
               cur_col_in = '0;
               if (cur_row_ff == tcw_pkg::ROW_LAST) begin
                  scroll_in = 1'b1;
               end else begin
                  cur_row_in = cur_row_ff + 1'b1;
               end
            end else begin
               acc_we_in   = 1'b1;
               res_cell_in = tcw_pkg::make_cell(item_char_ff, color_ff);
               if (cur_col_ff == tcw_pkg::COL_LAST) begin
                  cur_col_in = '0;
                  if (cur_row_ff == tcw_pkg::ROW_LAST) begin
                     scroll_in = 1'b1;
                  end else begin
                     cur_row_in = cur_row_ff + 1'b1;
                  end
               end else begin
                  cur_col_in = cur_col_ff + 1'b1;
               end
            end
         end
         S_ACCESS: begin
            if (item_cmd_ff == tcw_pkg::CMD_READ) begin
               state_in = S_RDWAIT;
            end else if (scroll_ff) begin
               // old top row becomes the new bottom row
               state_in    = S_CLEAR;
               clr_addr_in = clr_base;
               clr_cnt_in  = '0;
               top_in      = (top_ff == tcw_pkg::ROW_LAST) ? '0 : top_ff + 1'b1;
            end else begin
               state_in = S_IDLE;
               done_in  = 1'b1;
            end
         end
         S_RDWAIT: begin
            res_cell_in = in_range_ff ? rd_data_ff : '0;
            state_in    = S_IDLE;
            done_in     = 1'b1;
         end
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            clr_cnt_in  = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == tcw_pkg::COL_LAST) begin
               state_in = S_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         done_ff       <= 1'b0;
         cur_row_ff    <= '0;
         cur_col_ff    <= '0;
         top_ff        <= '0;
         color_ff      <= tcw_pkg::RESET_COLOR;
         init_addr_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         done_ff       <= done_in;
         cur_row_ff    <= cur_row_in;
         cur_col_ff    <= cur_col_in;
         top_ff        <= top_in;
         color_ff      <= color_in;
         init_addr_ff  <= init_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_cmd_ff  <= req.command;
         item_char_ff <= req.char_code;
         item_rrow_ff <= req.read_row;
         item_rcol_ff <= req.read_col;
      end
      acc_row_ff    <= acc_row_in;
      acc_col_ff    <= acc_col_in;
      acc_we_ff     <= acc_we_in;
      in_range_ff   <= in_range_in;
      scroll_ff     <= scroll_in;
      res_cell_ff   <= res_cell_in;
      clr_addr_ff   <= clr_addr_in;
      clr_cnt_ff    <= clr_cnt_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_scroll_ff <= rsp_scroll_in;
   end

   // checks
   `TCW_ASSERT(a_cursor_range, (int'(cur_row_ff) < tcw_pkg::ROWS) && (int'(cur_col_ff) < tcw_pkg::COLUMNS) && (int'(top_ff) < tcw_pkg::ROWS), "cursor or top row out of range")
   `TCW_ASSERT(a_scroll_bottom, (state_ff == S_CLEAR) |-> (cur_row_ff == tcw_pkg::ROW_LAST), "row blanking while cursor is not on the bottom row")
   `TCW_ASSERT(a_clear_one_row, (state_ff == S_CLEAR) |-> (clr_cnt_ff <= tcw_pkg::COL_LAST), "row blanking ran past one row")
   `TCW_ASSERT_NEVER(a_done_busy, done_ff && (state_ff != S_IDLE), "result pending while another item is in flight")
   `TCW_ASSERT(a_rsp_source, $rose(rsp_valid_ff) |-> $past(done_ff), "response raised without a finished item")

endmodule

// ===== test/text_console_writer_tb.sv =====
// ----------------------------------------------------------------------------
// text console writer testbench
// Drives put and read requests and colour register writes into the console.
// Every response is checked field by field against its table row or a screen
// and cursor predictor kept in the bench. A short table of directed requests
// comes first, then four phases of random line, newline, backspace, read and
// noise sequences, each after a colour change. Both sides idle at random,
// and once the response side holds off long enough to stall the requests.
// ----------------------------------------------------------------------------
module text_console_writer_tb;

   localparam int CYCLE_LIMIT    = 500000;
   localparam int SETTLE_CYCLES  = tcw_pkg::COLUMNS + 16;
   localparam int PHASE_ITEMS    = 70;
   localparam int HOLD_OFF       = 400;
   localparam int HOLD_OFF_AFTER = 120;

   typedef struct packed {
      tcw_pkg::command_type           command;
      logic [tcw_pkg::CHAR_W-1:0]     char_code;
      logic [tcw_pkg::RROW_W-1:0]     read_row;
      logic [tcw_pkg::RCOL_W-1:0]     read_col;
   } console_request_type;

   typedef struct packed {
      logic [tcw_pkg::CELL_W-1:0]     cell_value;
      logic [tcw_pkg::RROW_W-1:0]     cursor_row;
      logic [tcw_pkg::RCOL_W-1:0]     cursor_col;
      logic [tcw_pkg::POS_W-1:0]      cursor_position;
      logic                           scrolled;
   } console_result_type;

   typedef struct packed {
      console_request_type            stim;
      logic                           typed;
      console_result_type             want;
   } directed_row_type;

   localparam int DIRECTED_COUNT = 22;

   // typed rows start from the reset screen in light grey
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{'{tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd0}, 1'b1, '{16'h0720, 5'd0, 7'd0, 11'd0, 1'b0}},
      '{'{tcw_pkg::CMD_READ, 8'h00, 5'd24, 7'd79}, 1'b1, '{16'h0720, 5'd0, 7'd0, 11'd0, 1'b0}},
      '{'{tcw_pkg::CMD_READ, 8'hFF, 5'd31, 7'd127}, 1'b1, '{16'h0000, 5'd0, 7'd0, 11'd0, 1'b0}},
      '{'{tcw_pkg::CMD_READ, 8'h00, 5'd25, 7'd0}, 1'b1, '{16'h0000, 5'd0, 7'd0, 11'd0, 1'b0}},
      '{'{tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd80}, 1'b1, '{16'h0000, 5'd0, 7'd0, 11'd0, 1'b0}},
      '{'{tcw_pkg::CMD_PUT, 8'h08, 5'd0, 7'd0}, 1'b1, '{16'h0720, 5'd0, 7'd0, 11'd0, 1'b0}},
      '{'{tcw_pkg::CMD_PUT, 8'h41, 5'd0, 7'd0}, 1'b1, '{16'h0741, 5'd0, 7'd1, 11'd1, 1'b0}},
      '{'{tcw_pkg::CMD_PUT, 8'h00, 5'd0, 7'd0}, 1'b1, '{16'h0700, 5'd0, 7'd2, 11'd2, 1'b0}},
      '{'{tcw_pkg::CMD_PUT, 8'hFF, 5'd31, 7'd127}, 1'b1, '{16'h07FF, 5'd0, 7'd3, 11'd3, 1'b0}},
      '{'{tcw_pkg::CMD_PUT, 8'h08, 5'd0, 7'd0}, 1'b1, '{16'h0720, 5'd0, 7'd2, 11'd2, 1'b0}},
      '{'{tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd1}, 1'b1, '{16'h0700, 5'd0, 7'd2, 11'd2, 1'b0}},
      '{'{tcw_pkg::CMD_PUT, 8'h0A, 5'd0, 7'd0}, 1'b1, '{16'h0000, 5'd1, 7'd0, 11'd80, 1'b0}},
      '{'{tcw_pkg::CMD_PUT, 8'h08, 5'd0, 7'd0}, 1'b1, '{16'h0720, 5'd0, 7'd79, 11'd79, 1'b0}},
      '{'{tcw_pkg::CMD_PUT, 8'h78, 5'd0, 7'd0}, 1'b1, '{16'h0778, 5'd1, 7'd0, 11'd80, 1'b0}},
      '{'{tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd79}, 1'b1, '{16'h0778, 5'd1, 7'd0, 11'd80, 1'b0}},
      '{'{tcw_pkg::CMD_PUT, 8'h0D, 5'd0, 7'd0}, 1'b1, '{16'h070D, 5'd1, 7'd1, 11'd81, 1'b0}},
      '{'{tcw_pkg::CMD_PUT, 8'h09, 5'd0, 7'd0}, 1'b1, '{16'h0709, 5'd1, 7'd2, 11'd82, 1'b0}},
      '{'{tcw_pkg::CMD_PUT, 8'h80, 5'd0, 7'd0}, 1'b1, '{16'h0780, 5'd1, 7'd3, 11'd83, 1'b0}},
      '{'{tcw_pkg::CMD_READ, 8'h00, 5'd1, 7'd2}, 1'b1, '{16'h0780, 5'd1, 7'd3, 11'd83, 1'b0}},
      '{'{tcw_pkg::CMD_PUT, 8'h55, 5'd10, 7'd42}, 1'b0, '0},
      '{'{tcw_pkg::CMD_PUT, 8'hAA, 5'd21, 7'd85}, 1'b0, '0},
      '{'{tcw_pkg::CMD_PUT, 8'h0A, 5'd0, 7'd0}, 1'b0, '0}
   };

   logic clock;
   logic reset;

   tcw_req_if req_ch ();
   tcw_rsp_if rsp_ch ();
   tcw_csr_if csr_ch ();

   text_console_writer i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // predicted screen, cursor and colour
   logic [tcw_pkg::CELL_W-1:0] screen_shadow [tcw_pkg::DEPTH];
   int                         cur_row;
   int                         cur_col;
   logic [tcw_pkg::CHAR_W-1:0] shade;

   console_result_type         due_results [$];
   int unsigned                mismatches;
   int unsigned                results_taken;
   int unsigned                cycle_count;
   logic                       sender_steady;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, due_results.size());
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic advance_row();
      cur_row++;
      if (cur_row >= tcw_pkg::ROWS) begin
         for (int i = 0; i < (tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS; i++)
            screen_shadow[i] = screen_shadow[i + tcw_pkg::COLUMNS];
         for (int i = 0; i < tcw_pkg::COLUMNS; i++)
            screen_shadow[(tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS + i] =
               {shade, tcw_pkg::CH_SPACE};
         cur_row = tcw_pkg::ROWS - 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic console_result_type apply_console_item(input console_request_type r);
      console_result_type res;
      int                 pos;
      res = '0;
      if (r.command == tcw_pkg::CMD_READ) begin
         if (int'(r.read_row) < tcw_pkg::ROWS && int'(r.read_col) < tcw_pkg::COLUMNS)
            res.cell_value =
               screen_shadow[int'(r.read_row) * tcw_pkg::COLUMNS + int'(r.read_col)];
      end else if (r.char_code == tcw_pkg::CH_BACKSPACE) begin
         if (cur_col > 0) begin
            cur_col--;
         end else if (cur_row > 0) begin
            cur_row--;
            cur_col = tcw_pkg::COLUMNS - 1;
         end
         res.cell_value = {shade, tcw_pkg::CH_SPACE};
         screen_shadow[cur_row * tcw_pkg::COLUMNS + cur_col] = res.cell_value;
      end else if (r.char_code == tcw_pkg::CH_NEWLINE) begin
         cur_col = 0;
         res.scrolled = advance_row();
      end else begin
         res.cell_value = {shade, r.char_code};
         screen_shadow[cur_row * tcw_pkg::COLUMNS + cur_col] = res.cell_value;
         cur_col++;
         if (cur_col >= tcw_pkg::COLUMNS) begin
            cur_col = 0;
            res.scrolled = advance_row();
         end
      end
      pos = cur_row * tcw_pkg::COLUMNS + cur_col;
      res.cursor_row      = tcw_pkg::RROW_W'(cur_row);
      res.cursor_col      = tcw_pkg::RCOL_W'(cur_col);
      res.cursor_position = tcw_pkg::POS_W'(pos);
      return res;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned pick;
      if (sender_steady)
         return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return 0;
      if (pick < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic console_request_type make_put(input logic [tcw_pkg::CHAR_W-1:0] ch);
      console_request_type r;
      r.command   = tcw_pkg::CMD_PUT;
      r.char_code = ch;
      r.read_row  = tcw_pkg::RROW_W'($urandom);
      r.read_col  = tcw_pkg::RCOL_W'($urandom);
      return r;
   endfunction

   function automatic logic [tcw_pkg::CHAR_W-1:0] line_char();
      if ($urandom_range(0, 3) == 0)
         return tcw_pkg::CHAR_W'($urandom);
      return tcw_pkg::CHAR_W'($urandom_range(32, 126));
   endfunction

   task automatic send_request(input console_request_type r, input logic typed,
                               input console_result_type want);
      int unsigned        gap;
      console_result_type predicted;
      gap = pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.command   <= r.command;
      req_ch.char_code <= r.char_code;
      req_ch.read_row  <= r.read_row;
      req_ch.read_col  <= r.read_col;
      do @(posedge clock); while (!req_ch.ready);
      predicted = apply_console_item(r);
      due_results.push_back(typed ? want : predicted);
   endtask

   task automatic write_color(input logic [tcw_pkg::CHAR_W-1:0] color);
      csr_ch.valid      <= 1'b1;
      csr_ch.text_color <= color;
      do @(posedge clock); while (!csr_ch.ready);
      shade = color;
      csr_ch.valid <= 1'b0;
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      // row blanking for a scroll ends before its result, so none is still running
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_sequence(output int unsigned count);
      int unsigned         kind;
      int unsigned         len;
      console_request_type r;
      count = 0;
      kind  = $urandom_range(0, 9);
      case (kind)
         5: begin
            len = $urandom_range(1, 8);
            repeat (len) begin
               send_request(make_put(tcw_pkg::CH_NEWLINE), 1'b0, '0);
               count++;
            end
         end
         6: begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 4);
            repeat (len) begin
               send_request(make_put(tcw_pkg::CH_BACKSPACE), 1'b0, '0);
               count++;
            end
         end
         7: begin
            len = $urandom_range(1, 4);
            repeat (len) begin
               r.command   = tcw_pkg::CMD_READ;
               r.char_code = tcw_pkg::CHAR_W'($urandom);
               if ($urandom_range(0, 4) == 0) begin
                  r.read_row = tcw_pkg::RROW_W'($urandom);
                  r.read_col = tcw_pkg::RCOL_W'($urandom);
               end else begin
                  r.read_row = tcw_pkg::RROW_W'($urandom_range(0, tcw_pkg::ROWS - 1));
                  r.read_col = tcw_pkg::RCOL_W'($urandom_range(0, tcw_pkg::COLUMNS - 1));
               end
               send_request(r, 1'b0, '0);
               count++;
            end
         end
         8: begin
            len = $urandom_range(1, 3);
            repeat (len) begin
               r.command   = tcw_pkg::command_type'(1'($urandom_range(0, 1)));
               r.char_code = tcw_pkg::CHAR_W'($urandom);
               r.read_row  = tcw_pkg::RROW_W'($urandom);
               r.read_col  = tcw_pkg::RCOL_W'($urandom);
               send_request(r, 1'b0, '0);
               count++;
            end
         end
         default: begin
            // a line of text, long enough now and then to wrap
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(75, 90) : $urandom_range(0, 6);
            repeat (len) begin
               send_request(make_put(line_char()), 1'b0, '0);
               count++;
            end
            if ($urandom_range(0, 4) != 0) begin
               send_request(make_put(tcw_pkg::CH_NEWLINE), 1'b0, '0);
               count++;
            end
         end
      endcase
   endtask

   function automatic void check_field(input string what, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
      end
   endfunction

   always @(posedge clock) begin : result_check
      console_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_taken++;
         if (due_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, cell %0h cursor %0d,%0d", $time,
                     rsp_ch.cell_value, rsp_ch.cursor_row, rsp_ch.cursor_col);
         end else begin
            want = due_results.pop_front();
            check_field("cell_value", want.cell_value, rsp_ch.cell_value);
            check_field("cursor_row", want.cursor_row, rsp_ch.cursor_row);
            check_field("cursor_col", want.cursor_col, rsp_ch.cursor_col);
            check_field("cursor_position", want.cursor_position, rsp_ch.cursor_position);
            check_field("scrolled", want.scrolled, rsp_ch.scrolled);
         end
      end
   end

   initial begin : result_pacing
      int unsigned pick;
      int unsigned hold;
      logic        held_off;
      held_off = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!held_off && results_taken >= HOLD_OFF_AFTER) begin
            // long stall so the request side backs up
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
            held_off = 1'b1;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               rsp_ch.ready <= 1'b1;
               hold = $urandom_range(1, 20);
            end else if (pick < 90) begin
               rsp_ch.ready <= 1'b0;
               hold = $urandom_range(1, 3);
            end else if (pick < 97) begin
               rsp_ch.ready <= 1'b0;
               hold = $urandom_range(10, 40);
            end else begin
               rsp_ch.ready <= 1'b1;
               hold = $urandom_range(50, 150);
            end
            repeat (hold) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int unsigned                sent;
      int unsigned                count;
      logic [tcw_pkg::CHAR_W-1:0] color;
      mismatches    = 0;
      results_taken = 0;
      cycle_count   = 0;
      sender_steady = 1'b0;
      shade         = tcw_pkg::RESET_COLOR;
      cur_row       = 0;
      cur_col       = 0;
      for (int i = 0; i < tcw_pkg::DEPTH; i++)
         screen_shadow[i] = {tcw_pkg::RESET_COLOR, tcw_pkg::CH_SPACE};

      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.command    <= tcw_pkg::CMD_PUT;
      req_ch.char_code  <= '0;
      req_ch.read_row   <= '0;
      req_ch.read_col   <= '0;
      csr_ch.valid      <= 1'b0;
      csr_ch.text_color <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++)
         send_request(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

      for (int phase = 0; phase < 4; phase++) begin
         drain_results();
         case (phase)
            0:       color = 8'h00;
            1:       color = 8'hFF;
            default: color = tcw_pkg::CHAR_W'($urandom);
         endcase
         write_color(color);
         sender_steady = (phase == 1);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            run_sequence(count);
            sent += count;
         end
      end

      drain_results();
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
